// ----- hdl/ppip_pkg.sv -----
// Shared types, widths and codes for the pivot partition block.
`default_nettype none
package ppip_pkg;

  localparam int KEY_W     = 64;
  localparam int POS_W     = 10;
  // Pointer span covers 0 .. 1024 (one past the last 10-bit position).
  localparam int PTR_W     = POS_W + 1;
  localparam int ACT_W     = 2;
  localparam int DEPTH_DEF = 1024;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CRACK = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [ACT_W-1:0]        act_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;        // capture the accepted item
    logic wr_item;      // write key_value at address
    logic rd_addr;      // read entry at address
    logic rd_lp;        // read entry at left pointer
    logic rd_rp;        // read entry at right pointer
    logic lp_inc;
    logic rp_dec;
    logic save_lkey;    // hold the left key for a swap
    logic wr_lp_rdata;  // first half of swap
    logic wr_rp_lkey;   // second half of swap
    logic load_res;     // move result into the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic lp_lt_rp;     // left <= right
    logic lp1_lt_rp;    // left < right
    logic below;        // read data below pivot
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/ppip_in_if.sv -----
// Input channel: one write, read or crack item per transfer.
`default_nettype none
interface ppip_in_if;
  import ppip_pkg::*;

  logic valid;
  logic ready;
  act_t action;
  pos_t address;
  key_t key_value;
  pos_t range_start;
  pos_t range_end;
  key_t pivot;

  modport source (output valid, action, address, key_value, range_start, range_end, pivot,
                  input ready);
  modport sink (input valid, action, address, key_value, range_start, range_end, pivot,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/ppip_out_if.sv -----
// Result channel: one result per accepted item.
`default_nettype none
interface ppip_out_if;
  import ppip_pkg::*;

  logic valid;
  logic ready;
  key_t read_key;
  pos_t split_position;

  modport source (output valid, read_key, split_position, input ready);
  modport sink (input valid, read_key, split_position, output ready);
endinterface
`default_nettype wire

// ----- hdl/ppip_ctrl.sv -----
// Sequencer for write, read and the two-pointer crack loop.
`default_nettype none
module ppip_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  input  ppip_pkg::act_t  in_action,
  output logic            in_ready,
  input  wire             out_ready,
  output logic            out_valid,
  input  ppip_pkg::sts_t  sts,
  output ppip_pkg::cmd_t  cmd
);
  import ppip_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_RD, S_LCHK, S_LEVAL, S_RCHK, S_REVAL, S_SWAP, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.latch = 1'b1;
          unique case (in_action)
            ACT_WRITE: state_nxt = S_WR;
            ACT_READ:  state_nxt = S_RD;
            ACT_CRACK: state_nxt = S_LCHK;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_WR: begin
        cmd.wr_item = 1'b1;
        state_nxt   = S_FIN;
      end
      S_RD: begin
        cmd.rd_addr = 1'b1;
        state_nxt   = S_FIN;
      end
      S_LCHK: begin
        if (sts.lp_lt_rp) begin
          cmd.rd_lp = 1'b1;
          state_nxt = S_LEVAL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_LEVAL: begin
        if (sts.below) begin
          cmd.lp_inc = 1'b1;
          state_nxt  = S_LCHK;
        end else begin
          cmd.save_lkey = 1'b1;
          state_nxt     = S_RCHK;
        end
      end
      S_RCHK: begin
        if (sts.lp_lt_rp) begin
          cmd.rd_rp = 1'b1;
          state_nxt = S_REVAL;
        end else begin
          state_nxt = S_LCHK;
        end
      end
      S_REVAL: begin
        if (!sts.below) begin
          cmd.rp_dec = 1'b1;
          state_nxt  = S_RCHK;
        end else if (sts.lp1_lt_rp) begin
          cmd.wr_lp_rdata = 1'b1;
          state_nxt       = S_SWAP;
        end else begin
          // right pointer met left on a low key: outer loop steps over it
          state_nxt = S_LCHK;
        end
      end
      S_SWAP: begin
        cmd.wr_rp_lkey = 1'b1;
        cmd.lp_inc     = 1'b1;
        cmd.rp_dec     = 1'b1;
        state_nxt      = S_LCHK;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_res  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result appeared outside finish step");

  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWAP) |-> ($past(state_r) == S_REVAL))
    else $error("swap second half without first half");

endmodule
`default_nettype wire

// ----- hdl/ppip_dp.sv -----
// Column store, crack pointers, item capture and result register.
`default_nettype none
module ppip_dp #(
  parameter int COLUMN_DEPTH = ppip_pkg::DEPTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  ppip_pkg::cmd_t   cmd,
  output ppip_pkg::sts_t   sts,
  input  ppip_pkg::act_t   in_action,
  input  ppip_pkg::pos_t   in_address,
  input  ppip_pkg::key_t   in_key_value,
  input  ppip_pkg::pos_t   in_range_start,
  input  ppip_pkg::pos_t   in_range_end,
  input  ppip_pkg::key_t   in_pivot,
  output ppip_pkg::key_t   out_read_key,
  output ppip_pkg::pos_t   out_split_position
);
  import ppip_pkg::*;

  localparam int AW = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;

  key_t           col_mem_r [COLUMN_DEPTH];
  key_t           rd_data_r;
  key_t           lkey_r;
  act_t           act_r;
  pos_t           addr_r;
  key_t           key_r;
  key_t           pivot_r;
  ptr_t           lp_r, rp_r;
  key_t           res_key_r;
  pos_t           res_split_r;

  logic           addr_ok;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_idx, wr_idx;
  key_t           wr_data;
  ptr_t           rp_init;
  ptr_t           rp_m1;
  ptr_t           last_pos;

  assign addr_ok = int'(addr_r) < COLUMN_DEPTH;
  assign rp_m1   = rp_r - PTR_W'(1);
  assign rp_init = (int'(in_range_end) >= COLUMN_DEPTH) ? PTR_W'(COLUMN_DEPTH)
                                                        : PTR_W'(in_range_end) + PTR_W'(1);
  assign last_pos = (lp_r == '0) ? '0 : lp_r - PTR_W'(1);

  assign sts.lp_lt_rp  = lp_r < rp_r;
  assign sts.lp1_lt_rp = (lp_r + PTR_W'(1)) < rp_r;
  assign sts.below     = rd_data_r < pivot_r;

  always_comb begin
    rd_en  = cmd.rd_lp || cmd.rd_rp || (cmd.rd_addr && addr_ok);
    rd_idx = AW'(addr_r);
    if (cmd.rd_lp) begin
      rd_idx = AW'(lp_r);
    end else if (cmd.rd_rp) begin
      rd_idx = AW'(rp_m1);
    end
    wr_en   = cmd.wr_lp_rdata || cmd.wr_rp_lkey || (cmd.wr_item && addr_ok);
    wr_idx  = AW'(addr_r);
    wr_data = key_r;
    if (cmd.wr_lp_rdata) begin
      wr_idx  = AW'(lp_r);
      wr_data = rd_data_r;
    end else if (cmd.wr_rp_lkey) begin
      wr_idx  = AW'(rp_m1);
      wr_data = lkey_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      col_mem_r[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= col_mem_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= in_action;
      addr_r  <= in_address;
      key_r   <= in_key_value;
      pivot_r <= in_pivot;
      lp_r    <= PTR_W'(in_range_start);
      rp_r    <= rp_init;
    end else begin
      if (cmd.lp_inc) begin
        lp_r <= lp_r + PTR_W'(1);
      end
      if (cmd.rp_dec) begin
        rp_r <= rp_m1;
      end
    end
    if (cmd.save_lkey) begin
      lkey_r <= rd_data_r;
    end
    if (cmd.load_res) begin
      res_key_r   <= (act_r == ACT_READ && addr_ok) ? rd_data_r : '0;
      res_split_r <= (act_r == ACT_CRACK) ? last_pos[POS_W-1:0] : '0;
    end
  end

  assign out_read_key       = res_key_r;
  assign out_split_position = res_split_r;

  a_lp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_lp |-> (int'(lp_r) < COLUMN_DEPTH))
    else $error("left pointer outside the column");

  a_rp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_rp |-> (rp_r != '0) && (int'(rp_m1) < COLUMN_DEPTH))
    else $error("right pointer outside the column");

  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_lp_rdata |=> cmd.wr_rp_lkey && $stable(lp_r) && $stable(rp_r))
    else $error("swap halves out of step");

endmodule
`default_nettype wire

// ----- hdl/pivot_partition_in_place.sv -----
// Top level: column store with write, read and in-place crack around a pivot.
//
//   channel   dir  transfer when        payload
//   in_ch     in   valid && ready       action, address, key_value, range_start,
//                                       range_end, pivot
//   out_ch    out  valid && ready       read_key, split_position
//
// Write and read: one memory access in an access state, then the finish step.
// Crack: a check and an evaluate state per key visited plus a swap state per swap,
// paced by the single read port and single write port of the store.
// One item is in work at a time; the next is taken while a result waits in the
// output register. Stalls on out_ch hold the block in its finish step.
// Synchronous active-low reset clears control only; the store is not cleared.
`default_nettype none
module pivot_partition_in_place #(
  parameter int COLUMN_DEPTH = ppip_pkg::DEPTH_DEF
) (
  input  wire    clk,
  input  wire    rst_n,
  ppip_in_if.sink    in_ch,
  ppip_out_if.source out_ch
);
  import ppip_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ppip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppip_dp #(
    .COLUMN_DEPTH (COLUMN_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_ch.action),
    .in_address         (in_ch.address),
    .in_key_value       (in_ch.key_value),
    .in_range_start     (in_ch.range_start),
    .in_range_end       (in_ch.range_end),
    .in_pivot           (in_ch.pivot),
    .out_read_key       (out_ch.read_key),
    .out_split_position (out_ch.split_position)
  );

endmodule
`default_nettype wire

// ----- bench/tb_pivot_partition_in_place.sv -----
// Self-checking testbench for pivot_partition_in_place: writes, reads and cracks vs. a shadow column.
`timescale 1ns / 100ps
`default_nettype none
module tb_pivot_partition_in_place;
  import ppip_pkg::*;

  localparam int   COLUMN_DEPTH = DEPTH_DEF;
  localparam int   ITEM_TARGET  = 580;
  localparam int   QUIET_AFTER  = 520;
  localparam int   CYCLE_LIMIT  = 1_000_000;
  localparam int   LONG_HOLD    = 300;
  localparam int   SETTLE       = 20;
  localparam int   SHORT_CRACK  = 64;
  localparam int   MAX_BIG      = 6;
  localparam act_t ACT_UNUSED   = 2'd3;
  localparam key_t KEY_MIN      = {1'b1, {63{1'b0}}};
  localparam key_t KEY_MAX      = {1'b0, {63{1'b1}}};

  typedef struct {
    act_t action;
    pos_t address;
    key_t key_value;
    pos_t range_start;
    pos_t range_end;
    key_t pivot;
  } column_op_t;

  typedef struct {
    key_t read_key;
    pos_t split_position;
  } column_res_t;

  // Shadow copy of the column; predicts one result per transfer and checks it.
  class column_shadow;
    key_t        column [COLUMN_DEPTH];
    column_res_t due_results [$];
    int          errors;
    int          checked;

    function automatic pos_t partition_range(pos_t lo_p, pos_t hi_p, key_t pv);
      int   left;
      int   right;
      int   last;
      key_t t;
      left  = lo_p;
      right = (hi_p > COLUMN_DEPTH - 1) ? COLUMN_DEPTH - 1 : hi_p;
      while (left <= right) begin
        if (column[left] < pv) begin
          left++;
        end else begin
          while (right >= left && !(column[right] < pv)) right--;
          if (left < right) begin
            t             = column[left];
            column[left]  = column[right];
            column[right] = t;
            left++;
            right--;
          end
        end
      end
      last = left - 1;
      if (last < 0) last = 0;
      return pos_t'(last);
    endfunction

    function void note_item(column_op_t op);
      column_res_t res;
      res.read_key       = '0;
      res.split_position = '0;
      case (op.action)
        ACT_WRITE: begin
          if (op.address < COLUMN_DEPTH) column[op.address] = op.key_value;
        end
        ACT_READ: begin
          if (op.address < COLUMN_DEPTH) res.read_key = column[op.address];
        end
        ACT_CRACK: begin
          res.split_position = partition_range(op.range_start, op.range_end, op.pivot);
        end
        default: ;
      endcase
      due_results = {due_results, res};
    endfunction

    function void check_result(key_t rk, pos_t sp);
      column_res_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing pending: read_key %0d split_position %0d", rk, sp);
        errors++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (rk !== want.read_key) begin
        $error("read_key: expected %0d, actual %0d", want.read_key, rk);
        errors++;
      end
      if (sp !== want.split_position) begin
        $error("split_position: expected %0d, actual %0d", want.split_position, sp);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ppip_in_if  in_ch ();
  ppip_out_if out_ch ();

  pivot_partition_in_place dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  column_shadow shadow;
  bit           written [COLUMN_DEPTH];
  bit           quiet;
  bit           calm;
  bit           hold_request;
  int           cycles;
  int           sent;
  int           n_write;
  int           n_read;
  int           n_crack;
  int           n_unused;
  int           big_cracks;
  int           longest_crack;

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      shadow.check_result(out_ch.read_key, out_ch.split_position);
    end
  end

  // Receiver: short random stalls, long ready stretches, one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else @(posedge clk);
    end
  end

  function automatic key_t rand_bits64();
    return {$urandom, $urandom};
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(0, 7))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2, 3, 4: return key_t'($urandom_range(0, 16)) - 64'sd8;
      default: return rand_bits64();
    endcase
  endfunction

  function automatic column_op_t blank_op(act_t a);
    column_op_t op;
    op.action      = a;
    op.address     = pos_t'($urandom);
    op.key_value   = rand_bits64();
    op.range_start = pos_t'($urandom);
    op.range_end   = pos_t'($urandom);
    op.pivot       = rand_bits64();
    return op;
  endfunction

  function automatic pos_t any_written();
    int a;
    a = $urandom_range(0, COLUMN_DEPTH - 1);
    while (!written[a]) a = (a + 1) % COLUMN_DEPTH;
    return pos_t'(a);
  endfunction

  // Holds valid across back-to-back transfers unless a random gap is put in; returns at the accepting edge.
  task automatic send(input column_op_t op);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= op.action;
    in_ch.address     <= op.address;
    in_ch.key_value   <= op.key_value;
    in_ch.range_start <= op.range_start;
    in_ch.range_end   <= op.range_end;
    in_ch.pivot       <= op.pivot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    shadow.note_item(op);
    sent++;
    case (op.action)
      ACT_WRITE: n_write++;
      ACT_READ:  n_read++;
      ACT_CRACK: n_crack++;
      default:   n_unused++;
    endcase
  endtask

  task automatic send_write(input pos_t a, input key_t k);
    column_op_t op;
    op           = blank_op(ACT_WRITE);
    op.address   = a;
    op.key_value = k;
    written[a]   = 1'b1;
    send(op);
  endtask

  task automatic send_read(input pos_t a);
    column_op_t op;
    op         = blank_op(ACT_READ);
    op.address = a;
    send(op);
  endtask

  task automatic send_crack(input pos_t lo, input pos_t hi, input key_t pv);
    column_op_t op;
    op             = blank_op(ACT_CRACK);
    op.range_start = lo;
    op.range_end   = hi;
    op.pivot       = pv;
    if (hi >= lo && int'(hi) - int'(lo) + 1 > longest_crack) longest_crack = hi - lo + 1;
    send(op);
  endtask

  // Range inside one written run: mostly short, a few spanning the whole run.
  task automatic crack_written_run();
    int   a;
    int   lo_r;
    int   hi_r;
    int   len;
    int   lo;
    int   pick;
    key_t pv;
    a    = any_written();
    lo_r = a;
    hi_r = a;
    while (lo_r > 0 && written[lo_r - 1]) lo_r--;
    while (hi_r < COLUMN_DEPTH - 1 && written[hi_r + 1]) hi_r++;
    len = hi_r - lo_r + 1;
    if (len > SHORT_CRACK && big_cracks < MAX_BIG && $urandom_range(0, 3) == 0) begin
      big_cracks++;
      lo = lo_r;
    end else begin
      if (len > SHORT_CRACK) len = SHORT_CRACK;
      len = $urandom_range(1, len);
      lo  = $urandom_range(lo_r, hi_r - len + 1);
    end
    pick = $urandom_range(lo, lo + len - 1);
    case ($urandom_range(0, 5))
      0, 1:    pv = shadow.column[pick];
      2:       pv = shadow.column[pick] + 64'sd1;
      3:       pv = ($urandom_range(0, 1) == 0) ? KEY_MIN : KEY_MAX;
      default: pv = pick_key();
    endcase
    send_crack(pos_t'(lo), pos_t'(lo + len - 1), pv);
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.due_results.size() != 0) @(posedge clk);
  endtask

  // One burst of consecutive writes, then a mix of operations over the column.
  task automatic run_episode();
    int len;
    int base;
    int k;
    int lo;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(2, 24);
    base = $urandom_range(0, COLUMN_DEPTH - len);
    for (k = 0; k < len; k++) send_write(pos_t'(base + k), pick_key());
    repeat ($urandom_range(4, 12)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: crack_written_run();
        4, 5, 6:    send_read(any_written());
        7:          send_write(pos_t'($urandom), pick_key());
        8: begin
          lo = $urandom_range(1, COLUMN_DEPTH - 1);
          send_crack(pos_t'(lo), pos_t'($urandom_range(0, lo - 1)), rand_bits64());
        end
        default:    send(blank_op(ACT_UNUSED));
      endcase
    end
  endtask

  initial begin
    int episode;
    shadow            = new();
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_WRITE;
    in_ch.address     = '0;
    in_ch.key_value   = '0;
    in_ch.range_start = '0;
    in_ch.range_end   = '0;
    in_ch.pivot       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: key extremes at both ends of the column, a range up to the last position, empty and single ranges.
    send_write(10'd0, KEY_MIN);
    send_write(10'd1, KEY_MAX);
    send_write(10'd2, 64'sd0);
    send_write(10'd3, -64'sd1);
    send_write(10'd1023, 64'sd5);
    send_write(10'd1022, KEY_MIN);
    send_write(10'd1021, 64'sd5);
    send_write(10'd1020, KEY_MAX);
    send_read(10'd0);
    send_read(10'd1);
    send_read(10'd1023);
    send_crack(10'd0, 10'd3, 64'sd0);
    send_read(10'd1);
    send_crack(10'd0, 10'd3, KEY_MIN);
    send_crack(10'd0, 10'd3, KEY_MAX);
    send_crack(10'd1020, 10'd1023, 64'sd5);
    send_crack(10'd1021, 10'd1021, 64'sd6);
    send_crack(10'd512, 10'd100, rand_bits64());
    send_crack(10'd1023, 10'd0, rand_bits64());
    send(blank_op(ACT_UNUSED));
    send_read(10'd1022);
    send_write(10'd1, 64'sd1);
    send_read(10'd1);

    episode = 0;
    while (sent < ITEM_TARGET) begin
      quiet = (sent >= QUIET_AFTER);
      calm  = ($urandom_range(0, 3) == 0);
      if (episode == 3) hold_request = 1'b1;
      if (episode == 8) wait_for_drain();
      run_episode();
      episode++;
    end

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    $display("Ran %0d items: %0d writes, %0d reads, %0d cracks, %0d unused; %0d results checked",
             sent, n_write, n_read, n_crack, n_unused, shadow.checked);
    $display("Longest crack %0d entries, %0d whole-run cracks, in %0d cycles",
             longest_crack, big_cracks, cycles);
    if (shadow.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/ppip_pkg.sv
hdl/ppip_in_if.sv
hdl/ppip_out_if.sv
hdl/ppip_ctrl.sv
hdl/ppip_dp.sv
hdl/pivot_partition_in_place.sv
bench/tb_pivot_partition_in_place.sv
